// ===== sv/pfa_pkg.sv =====
// Shared types, sizes and codes of the page frame allocator.
package pfa_pkg;

    // Frame store sizes
    localparam int NUM_PAGES  = 65536;
    localparam int COUNT_BITS = 8;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int TOP_W      = PAGE_W + 1;

    // Field widths of the transaction payloads
    localparam int CMD_W      = 3;
    localparam int FRAME_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int REFCNT_W   = 8;
    localparam int FREECNT_W  = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'd1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INC   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEC   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GET   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_LIMIT = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FRAME_W-1:0] page;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [FRAME_W-1:0]   alloc_page;
        logic [REFCNT_W-1:0]  ref_count;
        logic [FREECNT_W-1:0] free_pages;
    } t_out_item;

endpackage

// ===== sv/pfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/page_frame_allocator_refcount_unit.sv =====
// Page frame allocator: free-frame stack and per-frame reference counts.
//
// Each command has an accept cycle and an execute state: in the accept cycle the
// count of the addressed frame and the top of the free stack are read from
// their memories; in the execute state the result is formed and, once the
// output register can take it, the memories are written back as the command
// needs and the result goes to the output register. The registered read of
// the memories sets this split; a new command is taken only after the last
// result has gone to the output register. After reset the count memory is
// cleared one entry a cycle, and no command is taken until it is done;
// configuration writes are taken at any time. Every result reports the
// free-frame count after the command.
module page_frame_allocator_refcount_unit import pfa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
    localparam logic [PAGE_W-1:0]     LAST_FRAME = PAGE_W'(NUM_PAGES - 1);
    localparam logic [TOP_W-1:0]      TOP_FULL   = TOP_W'(NUM_PAGES);

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [PAGE_W-1:0]     r_clr_idx;
    logic [15:0]           r_first_page;
    logic [16:0]           r_page_limit;
    logic [TOP_W-1:0]      r_top;
    logic [TOP_W-1:0]      n_top;
    logic [CMD_W-1:0]      r_cmd;
    logic [FRAME_W-1:0]    r_page;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  in_fire;
    logic                  commit;
    logic [31:0]           in_page_ext;
    logic [31:0]           cur_page_ext;
    logic [31:0]           given_ext;
    logic [31:0]           top_ext;
    logic [31:0]           cnt_ext;
    logic [PAGE_W-1:0]     ref_raddr;
    logic [COUNT_BITS-1:0] ref_q;
    logic [FRAME_W-1:0]    stk_q;
    logic [TOP_W-1:0]      top_m1;
    logic                  in_table;
    logic                  freeable;
    logic                  stk_full;

    logic                  ex_ref_we;
    logic [PAGE_W-1:0]     ex_ref_addr;
    logic [COUNT_BITS-1:0] ex_ref_wd;
    logic                  ex_stk_we;
    logic [STATUS_W-1:0]   ex_status;
    logic [FRAME_W-1:0]    ex_given;
    logic [COUNT_BITS-1:0] ex_count;

    logic                  ref_we;
    logic [PAGE_W-1:0]     ref_waddr;
    logic [COUNT_BITS-1:0] ref_wdata;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_fire      = i_in_valid && o_in_ready;
    assign commit       = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // Frame numbers widened for compare and address slicing
    assign in_page_ext  = 32'(i_in_item.page);
    assign cur_page_ext = 32'(r_page);
    assign given_ext    = 32'(stk_q);
    assign top_m1       = r_top - TOP_W'(1);

    assign ref_raddr = (r_state == S_IDLE) ? in_page_ext[PAGE_W-1:0]
                                           : cur_page_ext[PAGE_W-1:0];

    assign in_table = (cur_page_ext < 32'(NUM_PAGES));
    assign freeable = in_table && (r_page >= r_first_page)
                      && ({1'b0, r_page} < r_page_limit);
    assign stk_full = (r_top == TOP_FULL);

    // Form the result and the write-back of the current command
    always_comb begin
        ex_ref_we   = 1'b0;
        ex_ref_addr = cur_page_ext[PAGE_W-1:0];
        ex_ref_wd   = ref_q;
        ex_stk_we   = 1'b0;
        ex_status   = STAT_OK;
        ex_given    = '0;
        ex_count    = '0;
        n_top       = r_top;
        case (r_cmd) inside
            CMD_ADD: begin
                if (!freeable) begin
                    ex_status = STAT_RANGE;
                end else begin
                    ex_ref_we = 1'b1;
                    ex_ref_wd = '0;
                    if (stk_full) begin
                        ex_status = STAT_FULL;
                    end else begin
                        ex_stk_we = 1'b1;
                        n_top     = r_top + TOP_W'(1);
                    end
                end
            end
            CMD_FREE: begin
                if (!freeable) begin
                    ex_status = STAT_RANGE;
                end else if (ref_q != '0) begin
                    ex_ref_we = 1'b1;
                    ex_ref_wd = ref_q - COUNT_ONE;
                    ex_count  = ref_q - COUNT_ONE;
                end else if (stk_full) begin
                    ex_status = STAT_FULL;
                end else begin
                    ex_stk_we = 1'b1;
                    n_top     = r_top + TOP_W'(1);
                end
            end
            CMD_ALLOC: begin
                if (r_top == '0) begin
                    ex_status = STAT_EMPTY;
                end else begin
                    n_top       = top_m1;
                    ex_given    = stk_q;
                    ex_count    = COUNT_ONE;
                    ex_ref_addr = given_ext[PAGE_W-1:0];
                    ex_ref_wd   = COUNT_ONE;
                    ex_ref_we   = (given_ext < 32'(NUM_PAGES));
                end
            end
            CMD_INC, CMD_DEC, CMD_GET: begin
                ex_count = ref_q;
                if (!in_table) begin
                    ex_status = STAT_RANGE;
                    ex_count  = '0;
                end else if (r_cmd == CMD_INC) begin
                    if (ref_q == COUNT_MAX) begin
                        ex_status = STAT_LIMIT;
                    end else begin
                        ex_ref_we = 1'b1;
                        ex_ref_wd = ref_q + COUNT_ONE;
                        ex_count  = ref_q + COUNT_ONE;
                    end
                end else if (r_cmd == CMD_DEC) begin
                    if (ref_q == '0) begin
                        ex_status = STAT_LIMIT;
                    end else begin
                        ex_ref_we = 1'b1;
                        ex_ref_wd = ref_q - COUNT_ONE;
                        ex_count  = ref_q - COUNT_ONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign top_ext = 32'(n_top);
    assign cnt_ext = 32'(ex_count);

    // Count memory write port: clearing pass, else the committed update
    assign ref_we    = (r_state == S_CLEAR) || (commit && ex_ref_we);
    assign ref_waddr = (r_state == S_CLEAR) ? r_clr_idx : ex_ref_addr;
    assign ref_wdata = (r_state == S_CLEAR) ? '0 : ex_ref_wd;

    pfa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (ref_wdata),
        .i_raddr (ref_raddr),
        .o_rdata (ref_q)
    );

    pfa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (commit && ex_stk_we),
        .i_waddr (r_top[PAGE_W-1:0]),
        .i_wdata (r_page),
        .i_raddr (top_m1[PAGE_W-1:0]),
        .o_rdata (stk_q)
    );

    // Sequence: clear the counts, then alternate accept and execute
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == LAST_FRAME) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_top        <= '0;
            r_out_valid  <= 1'b0;
            r_first_page <= 16'd0;
            r_page_limit <= 17'd65536;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + PAGE_W'(1);
            end
            if (commit) begin
                r_top       <= n_top;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_FIRST_PAGE: r_first_page <= i_cfg_wdata[15:0];
                    CFG_PAGE_LIMIT: r_page_limit <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Hold the accepted command and the finished result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= i_in_item.cmd;
            r_page <= i_in_item.page;
        end
        if (commit) begin
            r_out_item.status     <= ex_status;
            r_out_item.alloc_page <= ex_given;
            r_out_item.ref_count  <= cnt_ext[REFCNT_W-1:0];
            r_out_item.free_pages <= top_ext[FREECNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/pfa_checker.sv =====
// Port-level checks of the page frame allocator, bound to its top level.
module pfa_checker import pfa_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_item
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    // One command in flight: busy in the cycle after an accepted transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command taken while one is in flight");

    // Out-of-range commands and allocations from an empty stack give no frame and no count
    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == STAT_RANGE || o_out_item.status == STAT_EMPTY)
        |-> o_out_item.alloc_page == '0 && o_out_item.ref_count == '0)
        else $error("rejected command reported a frame or a count");

    // A full stack reports every frame as free
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == STAT_FULL
        |-> o_out_item.free_pages == FREECNT_W'(NUM_PAGES))
        else $error("stack full reported with a short free count");

endmodule

bind page_frame_allocator_refcount_unit pfa_checker u_pfa_checker (.*);

// ===== tb/page_frame_allocator_refcount_unit_tb.sv =====
// Self-checking testbench for the page frame allocator with a frame-stack and count model.
module page_frame_allocator_refcount_unit_tb;
    import pfa_pkg::*;

    // Command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 170;
    localparam int NUM_PHASES     = 6;
    localparam int POOL_SIZE      = 8;

    // Free-frame stack and count model; holds the results still owed by the block
    class frame_scoreboard;
        logic [FRAME_W-1:0]    frames [NUM_PAGES];
        logic [COUNT_BITS-1:0] counts [NUM_PAGES];
        int unsigned           depth;
        logic [CFG_DATA_W-1:0] first_page;
        logic [CFG_DATA_W-1:0] page_limit;
        t_out_item             owed_q [$];
        int                    errors;

        function new();
            depth      = 0;
            first_page = '0;
            page_limit = CFG_DATA_W'(NUM_PAGES);
            errors     = 0;
            foreach (counts[i]) counts[i] = '0;
            foreach (frames[i]) frames[i] = '0;
        endfunction

        // Keep only the bits each register holds
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_FIRST_PAGE)
                first_page = {1'b0, val[FRAME_W-1:0]};
            else if (idx == CFG_PAGE_LIMIT)
                page_limit = val;
        endfunction

        function bit freeable(logic [FRAME_W-1:0] p);
            return ({1'b0, p} >= first_page) && ({1'b0, p} < page_limit)
                && (int'(p) < NUM_PAGES);
        endfunction

        function logic [STATUS_W-1:0] push_frame(logic [FRAME_W-1:0] p);
            if (depth >= NUM_PAGES)
                return STAT_FULL;
            frames[depth] = p;
            depth++;
            return STAT_OK;
        endfunction

        // Execute one command on the model and form its result
        function t_out_item apply_command(t_in_item it);
            t_out_item          r;
            logic [FRAME_W-1:0] p;
            logic [FRAME_W-1:0] given;
            r = '0;
            p = it.page;
            case (it.cmd)
                CMD_ADD: begin
                    if (!freeable(p)) begin
                        r.status = STAT_RANGE;
                    end else begin
                        counts[p] = '0;
                        r.status = push_frame(p);
                    end
                end
                CMD_FREE: begin
                    if (!freeable(p)) begin
                        r.status = STAT_RANGE;
                    end else begin
                        if (counts[p] != 0)
                            counts[p] = counts[p] - 1'b1;
                        else
                            r.status = push_frame(p);
                        r.ref_count = REFCNT_W'(counts[p]);
                    end
                end
                CMD_ALLOC: begin
                    if (depth == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        depth--;
                        given = frames[depth];
                        counts[given] = COUNT_BITS'(1);
                        r.alloc_page = given;
                        r.ref_count = REFCNT_W'(1);
                    end
                end
                CMD_INC, CMD_DEC, CMD_GET: begin
                    if (int'(p) >= NUM_PAGES) begin
                        r.status = STAT_RANGE;
                    end else begin
                        if (it.cmd == CMD_INC) begin
                            if (counts[p] == '1)
                                r.status = STAT_LIMIT;
                            else
                                counts[p] = counts[p] + 1'b1;
                        end else if (it.cmd == CMD_DEC) begin
                            if (counts[p] == '0)
                                r.status = STAT_LIMIT;
                            else
                                counts[p] = counts[p] - 1'b1;
                        end
                        r.ref_count = REFCNT_W'(counts[p]);
                    end
                end
                default: ;
            endcase
            r.free_pages = FREECNT_W'(depth);
            return r;
        endfunction

        task report_error(string msg);
            errors++;
            $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        // Note an accepted command transaction
        function void note_command(t_in_item it);
            owed_q.push_back(apply_command(it));
        endfunction

        // Compare a result transaction with the oldest owed one
        task check_result(t_out_item got);
            t_out_item exp;
            if (owed_q.size() == 0) begin
                report_error($sformatf("result with nothing owed: %h", got));
            end else begin
                exp = owed_q.pop_front();
                if (got.status !== exp.status)
                    report_error($sformatf("status %0d, model %0d", got.status, exp.status));
                if (got.alloc_page !== exp.alloc_page)
                    report_error($sformatf("alloc_page %h, model %h",
                                           got.alloc_page, exp.alloc_page));
                if (got.ref_count !== exp.ref_count)
                    report_error($sformatf("ref_count %0d, model %0d",
                                           got.ref_count, exp.ref_count));
                if (got.free_pages !== exp.free_pages)
                    report_error($sformatf("free_pages %0d, model %0d",
                                           got.free_pages, exp.free_pages));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_item;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_arm = 1'b0;
    logic        hold_done = 1'b0;

    frame_scoreboard sb = new();

    page_frame_allocator_refcount_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("page_frame_allocator_refcount_unit: mismatch");
        $finish;
    end

    // Sample both channels at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid === 1'b1 && out_ready)
                sb.check_result(out_item);
            if (in_valid && in_ready === 1'b1)
                sb.note_command(in_item);
        end
    end

    // Drive result ready; hold it low for one long stretch when armed
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_arm && !hold_done) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one command and return at the falling edge after it is taken
    task automatic send_command(input logic [CMD_W-1:0] c, input logic [FRAME_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item.cmd  = c;
        in_item.page = p;
        in_valid     = 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.owed_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_pacing(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Pick one command with a weighted mix, reserved codes included
    function automatic logic [CMD_W-1:0] pick_command();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return CMD_ADD;
        if (r < 35) return CMD_FREE;
        if (r < 55) return CMD_ALLOC;
        if (r < 70) return CMD_INC;
        if (r < 85) return CMD_DEC;
        if (r < 95) return CMD_GET;
        return $urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7;
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] first_tab [NUM_PHASES];
        logic [CFG_DATA_W-1:0] limit_tab [NUM_PHASES];
        logic [FRAME_W-1:0]    pool [POOL_SIZE];
        logic [FRAME_W-1:0]    pg;
        int                    lo;
        int                    hi;
        int                    sent;
        int                    k;

        first_tab = '{17'h00000, 17'h00100, 17'h0FFFF, 17'h00000, 17'h1ABCD, 17'h09000};
        limit_tab = '{17'h10000, 17'h00180, 17'h10000, 17'h00001, 17'h1FFFF, 17'h08000};

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty stack, count floor, reserved codes, pushes and pops
        set_pacing(10, 79);
        send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_GET, 16'h0000);
        send_command(CMD_DEC, 16'h0000);
        send_command(CMD_RSVD6, 16'hFFFF);
        send_command(CMD_RSVD7, 16'h1234);
        send_command(CMD_ADD, 16'h0000);
        send_command(CMD_ADD, 16'hFFFF);
        send_command(CMD_FREE, 16'h8000);
        send_command(CMD_INC, 16'hFFFF);
        send_command(CMD_FREE, 16'hFFFF);
        send_command(CMD_ALLOC, 16'hFFFF);
        send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_GET, 16'hFFFF);

        // Directed: window edges on add and free
        wait_idle();
        write_reg(CFG_FIRST_PAGE, 17'h00010);
        write_reg(CFG_PAGE_LIMIT, 17'h00020);
        send_command(CMD_ADD, 16'h000F);
        send_command(CMD_ADD, 16'h0020);
        send_command(CMD_FREE, 16'h0010);
        send_command(CMD_ADD, 16'h001F);
        send_command(CMD_FREE, 16'h000F);
        send_command(CMD_INC, 16'h000F);
        send_command(CMD_ALLOC, 16'h0000);

        // Drive one count to its ceiling and back down to its floor, pushing past both
        set_pacing(0, 0);
        pg = FRAME_W'($urandom);
        repeat (256) send_command(CMD_INC, pg);
        send_command(CMD_GET, pg);
        repeat (257) send_command(CMD_DEC, pg);

        // Random phases over several window settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            write_reg(CFG_FIRST_PAGE, first_tab[ph]);
            write_reg(CFG_PAGE_LIMIT, limit_tab[ph]);
            case (ph % 3)
                0: set_pacing(10, 79);
                1: set_pacing(79, 10);
                default: set_pacing(0, 0);
            endcase
            if (ph == 2)
                hold_arm = 1'b1;

            // Build a pool of pages around the window edges
            lo = int'(first_tab[ph][FRAME_W-1:0]);
            hi = (int'(limit_tab[ph]) < NUM_PAGES) ? int'(limit_tab[ph]) : NUM_PAGES;
            pool[0] = FRAME_W'(lo);
            pool[1] = FRAME_W'(lo - 1);
            pool[2] = FRAME_W'(hi);
            pool[3] = FRAME_W'(hi - 1);
            for (int i = 4; i < POOL_SIZE; i++)
                pool[i] = (lo < hi) ? FRAME_W'($urandom_range(hi - 1, lo))
                                    : FRAME_W'($urandom);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pg = pool[$urandom_range(POOL_SIZE - 1)];
                if ($urandom_range(1)) begin
                    // Frame lifetime: add, take references, drop them, hand out
                    k = $urandom_range(3);
                    send_command(CMD_ADD, pg);
                    repeat (k) send_command(CMD_INC, pg);
                    send_command(CMD_GET, pg);
                    repeat (k + 1) send_command(CMD_FREE, pg);
                    send_command(CMD_ALLOC, FRAME_W'($urandom));
                    sent += 2 * k + 4;
                end else begin
                    if ($urandom_range(9) < 3)
                        pg = FRAME_W'($urandom);
                    send_command(pick_command(), pg);
                    sent++;
                end
            end
        end

        // Drain and let the pipeline settle
        wait_idle();
        repeat (20) @(negedge clk);
        if (sb.errors == 0)
            $display("page_frame_allocator_refcount_unit: match");
        else
            $display("page_frame_allocator_refcount_unit: mismatch");
        $finish;
    end

endmodule
